// ===== rtl/rcst_pkg.sv =====
// rcst_pkg: shared constants and types for the row-choice closest-sum block.
// No dependencies; imported by rcst_dp, rcst_fin, the top level and the testbench.
package rcst_pkg;

  // Fixed field widths
  localparam int TGT_W = 10;  // target register
  localparam int OUT_W = 10;  // best_difference result

  // Step-stage control handed from the top level to the DP datapath
  typedef struct packed {
    logic go;        // item in the step stage is applied this cycle
    logic row_end;   // item closes a row
    logic mat_end;   // item closes the matrix
  } step_ctl_t;

endpackage : rcst_pkg

// ===== rtl/rcst_dp.sv =====
// rcst_dp: reachable-sum bitsets, over-target tracking and the per-element update.
// Depends on rcst_pkg (TGT_W, step_ctl_t).
module rcst_dp import rcst_pkg::*; #(
  parameter int TARGET_LIMIT = 1023,
  parameter int VALUE_BITS   = 8,
  localparam int SET_W = TARGET_LIMIT + 1,
  localparam int IDX_W = $clog2(SET_W),
  localparam int OVR_W = $clog2(2 * TARGET_LIMIT + 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  step_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [TGT_W-1:0]      target,
  output logic [SET_W-1:0]      snap_set,
  output logic [IDX_W-1:0]      snap_t,
  output logic [OVR_W-1:0]      snap_over,
  output logic                  snap_over_v
);

  localparam int SUM_W    = ((OVR_W > VALUE_BITS) ? OVR_W : VALUE_BITS) + 1;
  localparam int OVER_SAT = 2 * TARGET_LIMIT + 1;

  logic [SET_W-1:0] reach_now_r, reach_now_nxt;
  logic [SET_W-1:0] reach_next_r, reach_next_nxt;
  logic [OVR_W-1:0] over_now_r, over_now_nxt;
  logic             over_now_v_r, over_now_v_nxt;
  logic [OVR_W-1:0] over_next_r, over_next_nxt;
  logic             over_next_v_r, over_next_v_nxt;

  logic [IDX_W-1:0] eff_t;
  logic [SET_W-1:0] in_range, live, fits;
  logic [IDX_W:0]   lo_bound;
  logic [SET_W-1:0] hi_side, over_side, low_one;
  logic [IDX_W-1:0] set_idx;
  logic             set_any;
  logic [SUM_W-1:0] set_sum, ovr_sum, cand;
  logic             cand_v;
  logic [OVR_W-1:0] cand_sat;
  logic             take;
  logic [SET_W-1:0] upd_set;
  logic [OVR_W-1:0] upd_over;
  logic             upd_over_v;

  // clamp target to the set size
  always_comb begin
    if (32'(target) > 32'(TARGET_LIMIT)) begin
      eff_t = IDX_W'(TARGET_LIMIT);
    end else begin
      eff_t = IDX_W'(target);
    end
  end

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      in_range[i] = (IDX_W'(i) <= eff_t);
    end
  end

  assign live = reach_now_r & in_range;
  assign fits = (live << value) & in_range;

  // lowest live sum that overshoots once value is added
  always_comb begin
    if (SUM_W'(value) > SUM_W'(eff_t)) begin
      lo_bound = '0;
    end else begin
      lo_bound = (IDX_W + 1)'(SUM_W'(eff_t) - SUM_W'(value) + SUM_W'(1));
    end
    for (int i = 0; i < SET_W; i++) begin
      hi_side[i] = ((IDX_W + 1)'(i) >= lo_bound);
    end
  end

  assign over_side = live & hi_side;
  assign low_one   = over_side & (~over_side + SET_W'(1));
  assign set_any   = |over_side;

  always_comb begin
    set_idx = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (low_one[i]) set_idx = set_idx | IDX_W'(i);
    end
  end

  assign set_sum = SUM_W'(set_idx) + SUM_W'(value);
  assign ovr_sum = SUM_W'(over_now_r) + SUM_W'(value);

  always_comb begin
    if (over_now_v_r && (!set_any || ovr_sum < set_sum)) begin
      cand = ovr_sum;
    end else begin
      cand = set_sum;
    end
    cand_v = set_any | over_now_v_r;
    if (cand > SUM_W'(OVER_SAT)) begin
      cand_sat = OVR_W'(OVER_SAT);
    end else begin
      cand_sat = OVR_W'(cand);
    end
  end

  assign take       = cand_v && (!over_next_v_r || cand_sat < over_next_r);
  assign upd_set    = reach_next_r | fits;
  assign upd_over   = take ? cand_sat : over_next_r;
  assign upd_over_v = over_next_v_r | cand_v;

  assign snap_set    = upd_set;
  assign snap_t      = eff_t;
  assign snap_over   = upd_over;
  assign snap_over_v = upd_over_v;

  always_comb begin
    reach_now_nxt   = reach_now_r;
    reach_next_nxt  = reach_next_r;
    over_now_nxt    = over_now_r;
    over_now_v_nxt  = over_now_v_r;
    over_next_nxt   = over_next_r;
    over_next_v_nxt = over_next_v_r;
    if (ctl.go) begin
      priority if (ctl.mat_end) begin
        reach_now_nxt   = SET_W'(1);
        reach_next_nxt  = '0;
        over_now_nxt    = '0;
        over_now_v_nxt  = 1'b0;
        over_next_nxt   = '0;
        over_next_v_nxt = 1'b0;
      end else if (ctl.row_end) begin
        reach_now_nxt   = upd_set;
        reach_next_nxt  = '0;
        over_now_nxt    = upd_over;
        over_now_v_nxt  = upd_over_v;
        over_next_nxt   = '0;
        over_next_v_nxt = 1'b0;
      end else begin
        reach_next_nxt  = upd_set;
        over_next_nxt   = upd_over;
        over_next_v_nxt = upd_over_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_now_r   <= SET_W'(1);
      reach_next_r  <= '0;
      over_now_r    <= '0;
      over_now_v_r  <= 1'b0;
      over_next_r   <= '0;
      over_next_v_r <= 1'b0;
    end else begin
      reach_now_r   <= reach_now_nxt;
      reach_next_r  <= reach_next_nxt;
      over_now_r    <= over_now_nxt;
      over_now_v_r  <= over_now_v_nxt;
      over_next_r   <= over_next_nxt;
      over_next_v_r <= over_next_v_nxt;
    end
  end

endmodule : rcst_dp

// ===== rtl/rcst_fin.sv =====
// rcst_fin: end-of-matrix snapshot register, closest-sum search and result register.
// Depends on rcst_pkg (OUT_W).
module rcst_fin import rcst_pkg::*; #(
  parameter int TARGET_LIMIT = 1023,
  localparam int SET_W = TARGET_LIMIT + 1,
  localparam int IDX_W = $clog2(SET_W),
  localparam int OVR_W = $clog2(2 * TARGET_LIMIT + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             snap_load,
  input  logic [SET_W-1:0] snap_set,
  input  logic [IDX_W-1:0] snap_t,
  input  logic [OVR_W-1:0] snap_over,
  input  logic             snap_over_v,
  output logic             snap_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] out_best
);

  logic             fin_valid_r, fin_valid_nxt;
  logic [SET_W-1:0] fin_set_r;
  logic [IDX_W-1:0] fin_t_r;
  logic [OVR_W-1:0] fin_over_r;
  logic             fin_over_v_r;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_best_r;

  logic             out_free;
  logic [SET_W-1:0] in_range, cand, rev, top_one;
  logic [IDX_W-1:0] top_idx;
  logic             top_any;
  logic [OVR_W-1:0] gap, over_gap, best;

  assign out_free  = !out_valid_r || out_ready;
  assign snap_free = !fin_valid_r || out_free;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      in_range[i] = (IDX_W'(i) <= fin_t_r);
    end
  end

  // highest reachable sum not above target: reverse, isolate lowest one
  assign cand = fin_set_r & in_range;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      rev[i] = cand[SET_W-1-i];
    end
  end

  assign top_one = rev & (~rev + SET_W'(1));
  assign top_any = |cand;

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < SET_W; i++) begin
      if (top_one[i]) top_idx = top_idx | IDX_W'(SET_W - 1 - i);
    end
  end

  always_comb begin
    gap = OVR_W'(fin_t_r) - OVR_W'(top_idx);
    if (fin_over_r > OVR_W'(fin_t_r)) begin
      over_gap = fin_over_r - OVR_W'(fin_t_r);
    end else begin
      over_gap = OVR_W'(fin_t_r) - fin_over_r;
    end
    best = OVR_W'(TARGET_LIMIT);
    if (top_any && gap < best) best = gap;
    if (fin_over_v_r && over_gap < best) best = over_gap;
  end

  always_comb begin
    fin_valid_nxt = fin_valid_r;
    if (snap_load) begin
      fin_valid_nxt = 1'b1;
    end else if (out_free) begin
      fin_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? fin_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      fin_set_r    <= snap_set;
      fin_t_r      <= snap_t;
      fin_over_r   <= snap_over;
      fin_over_v_r <= snap_over_v;
    end
    if (out_free && fin_valid_r) begin
      out_best_r <= OUT_W'(best);
    end
  end

  assign out_valid = out_valid_r;
  assign out_best  = out_best_r;

endmodule : rcst_fin

// ===== rtl/row_choice_sum_closest_target.sv =====
// row_choice_sum_closest_target: top level, input beat register, target register, handshakes.
// Depends on rcst_pkg, rcst_dp and rcst_fin.
//
//   port group  dir  beat contents                        when taken
//   in_*        in   value, row_end, matrix_end           in_valid & in_ready
//   out_*       out  best_difference                      out_valid & out_ready
//   cfg_*       in   target (10 bits)                     cfg_valid & cfg_ready
//
// Flow: one input beat per clock unless a matrix-end beat waits. A beat is held
// in the input register, then its DP update (shift-OR over the reachable set plus
// the over-target priority search) commits as the beat leaves that register. A
// matrix-end beat's result passes the snapshot register, then the result register.
// Reset: synchronous; the reachable set returns to {0} directly, no sweep.
// Stalls: only a matrix-end beat waits, for a free snapshot slot; cfg_ready is
// always high.
module row_choice_sum_closest_target import rcst_pkg::*; #(
  parameter int TARGET_LIMIT = 1023,
  parameter int VALUE_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_row_end,
  input  logic                  in_matrix_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_best_difference,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TGT_W-1:0]      cfg_target
);

  localparam int SET_W = TARGET_LIMIT + 1;
  localparam int IDX_W = $clog2(SET_W);
  localparam int OVR_W = $clog2(2 * TARGET_LIMIT + 2);

  // target register
  logic [TGT_W-1:0] target_r, target_nxt;

  // input beat register
  logic                  itm_valid_r, itm_valid_nxt;
  logic [VALUE_BITS-1:0] itm_value_r;
  logic                  itm_row_r;
  logic                  itm_mat_r;

  logic      in_take;
  logic      itm_go;
  logic      snap_free;
  logic      snap_load;
  step_ctl_t step_ctl;

  logic [SET_W-1:0] snap_set;
  logic [IDX_W-1:0] snap_t;
  logic [OVR_W-1:0] snap_over;
  logic             snap_over_v;

  assign cfg_ready  = 1'b1;
  assign target_nxt = (cfg_valid && cfg_ready) ? cfg_target : target_r;

  // a row beat always proceeds; a matrix-end beat needs the snapshot slot
  assign itm_go    = itm_valid_r && (!itm_mat_r || snap_free);
  assign in_ready  = !itm_valid_r || itm_go;
  assign in_take   = in_valid && in_ready;
  assign snap_load = itm_go && itm_mat_r;

  always_comb begin
    itm_valid_nxt = itm_valid_r;
    if (in_take) begin
      itm_valid_nxt = 1'b1;
    end else if (itm_go) begin
      itm_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      itm_valid_r <= 1'b0;
    end else begin
      target_r    <= target_nxt;
      itm_valid_r <= itm_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      itm_value_r <= in_value;
      itm_row_r   <= in_row_end;
      itm_mat_r   <= in_matrix_end;
    end
  end

  assign step_ctl.go      = itm_go;
  assign step_ctl.row_end = itm_row_r;
  assign step_ctl.mat_end = itm_mat_r;

  rcst_dp #(
    .TARGET_LIMIT (TARGET_LIMIT),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (step_ctl),
    .value       (itm_value_r),
    .target      (target_r),
    .snap_set    (snap_set),
    .snap_t      (snap_t),
    .snap_over   (snap_over),
    .snap_over_v (snap_over_v)
  );

  rcst_fin #(
    .TARGET_LIMIT (TARGET_LIMIT)
  ) u_fin (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_load   (snap_load),
    .snap_set    (snap_set),
    .snap_t      (snap_t),
    .snap_over   (snap_over),
    .snap_over_v (snap_over_v),
    .snap_free   (snap_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_best    (out_best_difference)
  );

`ifndef SYNTHESIS
  // row beats never wait in the step stage
  a_row_beat_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (itm_valid_r && !itm_mat_r) |-> itm_go)
    else $error("row beat stalled in step stage");

  // result never exceeds TARGET_LIMIT
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_best_difference) <= 32'(TARGET_LIMIT)))
    else $error("best_difference above TARGET_LIMIT");

  // after reset: no result pending and input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");
`endif

endmodule : row_choice_sum_closest_target

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for row_choice_sum_closest_target (closest one-per-row sum).
// Depends on rcst_pkg and the block's RTL; predicts results with its own reachable-sum bitset.
module testbench;
  import rcst_pkg::*;

  localparam int LIMIT      = 1023;           // block's TARGET_LIMIT (default)
  localparam int OVER_CAP   = 2 * LIMIT + 1;  // over-target sums clamp here
  localparam int VAL_W      = 8;              // block's VALUE_BITS (default)
  localparam int MAX_VAL    = (1 << VAL_W) - 1;
  localparam int SETTLE     = 4;              // covers the beat register and its commit, with margin
  localparam int MAX_CYCLES = 300000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [VAL_W-1:0]  in_value;
  logic              in_row_end;
  logic              in_matrix_end;
  logic              out_valid;
  logic              out_ready;
  logic [OUT_W-1:0]  out_best_difference;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [TGT_W-1:0]  cfg_target;

  row_choice_sum_closest_target dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_value            (in_value),
    .in_row_end          (in_row_end),
    .in_matrix_end       (in_matrix_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_best_difference (out_best_difference),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_target          (cfg_target)
  );

  // Predicted block state: sums that still fit under the target, plus the
  // smallest sum that has gone over it, for the current and the next row.
  logic [LIMIT:0]   sums_now;
  logic [LIMIT:0]   sums_next;
  int               over_now;
  int               over_next;
  bit               over_now_ok;
  bit               over_next_ok;
  int               target_q;                 // mirror of the target register
  logic [OUT_W-1:0] diff_due[$];              // best differences still to come out

  int errors = 0;
  int cycles = 0;
  int sent   = 0;
  bit quiet  = 1'b0;                          // no idling on either side
  bit calm   = 1'b0;                          // no idling on the input side

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  task automatic clear_sums();
    sums_now     = '0;
    sums_now[0]  = 1'b1;
    sums_next    = '0;
    over_now     = 0;
    over_now_ok  = 1'b0;
    over_next    = 0;
    over_next_ok = 1'b0;
  endtask

  // Apply one element to the predicted state; push a result on matrix end.
  task automatic fold_element(input int v, input bit rend, input bit mend);
    int s;
    int t;
    int sum;
    int cand;
    int best;
    int d;
    bit cand_ok;
    t       = (target_q > LIMIT) ? LIMIT : target_q;
    cand    = 0;
    cand_ok = 1'b0;
    // Bits above the current target are left out entirely.
    for (s = 0; s <= t; s++) begin
      if (sums_now[s]) begin
        sum = s + v;
        if (sum <= t) begin
          sums_next[sum] = 1'b1;
        end else if (!cand_ok || sum < cand) begin
          cand    = sum;
          cand_ok = 1'b1;
        end
      end
    end
    // The stored over-target sum keeps competing.
    if (over_now_ok) begin
      sum = over_now + v;
      if (!cand_ok || sum < cand) begin
        cand    = sum;
        cand_ok = 1'b1;
      end
    end
    if (cand_ok) begin
      if (cand > OVER_CAP) cand = OVER_CAP;
      if (!over_next_ok || cand < over_next) begin
        over_next    = cand;
        over_next_ok = 1'b1;
      end
    end
    // Matrix end closes the row too.
    if (rend || mend) begin
      sums_now     = sums_next;
      sums_next    = '0;
      over_now     = over_next;
      over_now_ok  = over_next_ok;
      over_next    = 0;
      over_next_ok = 1'b0;
    end
    if (mend) begin
      // Largest fitting sum gives the smallest gap from below; nothing at all
      // reachable leaves the result at the limit.
      best = LIMIT;
      for (s = 0; s <= t; s++) begin
        if (sums_now[s]) best = t - s;
      end
      if (over_now_ok) begin
        d = (over_now > t) ? over_now - t : t - over_now;
        if (d < best) best = d;
      end
      diff_due.push_back(best[OUT_W-1:0]);
      clear_sums();
    end
  endtask

  // ---------------------------------------------------------------- drivers

  task automatic hold_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One input beat; valid stays up afterwards so back-to-back beats need no gap.
  task automatic send_element(input logic [VAL_W-1:0] v, input bit rend, input bit mend);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) hold_input($urandom_range(1, 10));
    in_valid      <= 1'b1;
    in_value      <= v;
    in_row_end    <= rend;
    in_matrix_end <= mend;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    fold_element(int'(v), rend, mend);
    sent++;
  endtask

  // Stop sending until every predicted result is out, then let the pipe drain.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (diff_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_target(input int t);
    settle_block();
    cfg_valid  <= 1'b1;
    cfg_target <= t[TGT_W-1:0];
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    target_q = t;
  endtask

  // Well-formed matrix: exactly rows rows of 1..5 elements. Half the values are
  // scaled so that sums land near the target.
  task automatic send_matrix(input int rows);
    int r;
    int c;
    int len;
    int lim;
    bit last;
    bit rend;
    logic [VAL_W-1:0] v;
    lim = (2 * target_q) / rows + 1;
    if (lim > MAX_VAL) lim = MAX_VAL;
    for (r = 0; r < rows; r++) begin
      len = $urandom_range(1, 5);
      for (c = 0; c < len; c++) begin
        v    = VAL_W'($urandom_range(0, 1) ? $urandom_range(0, MAX_VAL)
                                           : $urandom_range(0, lim));
        last = (r == rows - 1) && (c == len - 1);
        rend = (c == len - 1);
        // sometimes close the matrix with matrix end alone
        if (last && $urandom_range(0, 3) == 0) rend = 1'b0;
        send_element(v, rend, last);
      end
    end
  endtask

  // Loose flags: rows and matrices of arbitrary shape.
  task automatic send_noise(input int n);
    repeat (n) begin
      send_element(VAL_W'($urandom_range(0, MAX_VAL)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 9) == 0);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin : rx_side
    int gap;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 10);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Every result beat against the oldest prediction.
  always @(posedge clk) begin : check_results
    logic [OUT_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (diff_due.size() == 0) begin
        errors++;
        $display("%0t ERROR best_difference: expected none, actual %0d",
                 $time, out_best_difference);
      end else begin
        want = diff_due.pop_front();
        if (out_best_difference !== want) begin
          errors++;
          $display("%0t ERROR best_difference: expected %0d, actual %0d",
                   $time, want, out_best_difference);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Target left at its reset value of zero. A lone zero hits it exactly; nine
  // rows of 255 overshoot past the clamp, so the gap pins at the limit. The
  // last beat carries matrix end without row end.
  task automatic test_reset_target();
    send_element(8'd0, 1'b1, 1'b1);
    repeat (8) send_element(VAL_W'(MAX_VAL), 1'b1, 1'b0);
    send_element(VAL_W'(MAX_VAL), 1'b0, 1'b1);
  endtask

  // Largest target, extreme values mixed in every row.
  task automatic test_full_target();
    write_target(LIMIT);
    send_element(VAL_W'(MAX_VAL), 1'b0, 1'b0);
    send_element(8'd0,    1'b1, 1'b0);
    send_element(VAL_W'(MAX_VAL), 1'b0, 1'b0);
    send_element(8'd1,    1'b1, 1'b0);
    send_element(VAL_W'(MAX_VAL), 1'b0, 1'b0);
    send_element(8'd128,  1'b1, 1'b0);
    send_element(VAL_W'(MAX_VAL), 1'b0, 1'b1);
  endtask

  // Target lowered mid-matrix: the only reachable sum now sits above it and
  // is dropped, no over-target sum exists, so nothing is reachable.
  task automatic test_target_lowered();
    write_target(100);
    send_element(8'd50, 1'b1, 1'b0);
    write_target(10);
    send_element(8'd3,  1'b1, 1'b0);
    send_element(8'd0,  1'b0, 1'b1);
  endtask

  // Target raised mid-matrix: the stored over-target sum ends up below the
  // new target and its gap is taken the other way round.
  task automatic test_target_raised();
    write_target(100);
    send_element(8'd60, 1'b1, 1'b0);
    send_element(8'd60, 1'b1, 1'b0);
    write_target(500);
    send_element(8'd0,  1'b0, 1'b1);
  endtask

  // Phases of random matrices under changing targets; the last phase runs
  // with no idling at all, one phase with a steady sender.
  task automatic test_random_matrices();
    int p;
    int pick;
    int budget;
    int t;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: t = LIMIT;
        1: t = 0;
        2: t = $urandom_range(1, 40);
        default: t = $urandom_range(0, LIMIT);
      endcase
      calm  = (p == 3);
      quiet = (p == 5);
      write_target(t);
      budget = sent + 150;
      while (sent < budget) begin
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          send_noise($urandom_range(1, 4));
        end else begin
          send_matrix($urandom_range(1, 6));
          if (pick == 19) settle_block();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- run

  initial begin : run
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_value      <= '0;
    in_row_end    <= 1'b0;
    in_matrix_end <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_target    <= '0;
    target_q = 0;
    clear_sums();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_target();
    test_full_target();
    test_target_lowered();
    test_target_raised();
    test_random_matrices();

    settle_block();
    repeat (10) @(posedge clk);
    if (errors == 0 && diff_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
